/* rtl/arm_pkg.sv */
// Shared types and constants for the axis reduce-mean block.
package arm_pkg;
	localparam int SUM_W  = 32;
	localparam int CNT_W  = 16;
	localparam int ISZ_W  = 11;
	localparam int MEAN_W = 16;
	localparam int QUO_W  = 32;

	localparam logic [0:0] REG_INNER_SIZE   = 1'b0;
	localparam logic [0:0] REG_REDUCE_COUNT = 1'b1;

	// Divider request: signed dividend, unsigned divisor, position tag, block-end flag
	typedef struct packed {
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
		logic [9:0]       position;
		logic             block_end;
	} arm_div_req_t;
endpackage

/* rtl/arm_divider.sv */
// Sequential signed-by-unsigned divider, one quotient bit per cycle.
module arm_divider
	import arm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  arm_div_req_t        req,
	output logic                busy,
	output logic                done,
	output logic [MEAN_W-1:0]   mean,
	output logic [9:0]          position,
	output logic                block_end,
	input  logic                ack
);
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] div_q;
	logic             neg_q;
	logic [5:0]       step_q;
	logic             run_q;
	logic             done_q;
	logic [9:0]       pos_q;
	logic             end_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   shifted;
	logic [SUM_W-1:0] qs;
	logic signed [SUM_W-1:0] qv;

	assign busy = run_q | done_q;
	assign done = done_q;
	assign shifted = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	assign trial = shifted - {1'b0, div_q};

	// Restoring division step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
				neg_q  <= req.dividend[SUM_W-1];
				quo_q  <= req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
				rem_q  <= '0;
				div_q  <= req.divisor;
				pos_q  <= req.position;
				end_q  <= req.block_end;
			end else if (run_q) begin
				if (!trial[CNT_W]) begin
					rem_q <= trial;
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
				step_q <= step_q + 1'b1;
				if (step_q == 6'(SUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q && ack) begin
				done_q <= 1'b0;
			end
		end
	end

	// Sign restore and saturation
	always_comb begin
		qs = neg_q ? (~quo_q + 1'b1) : quo_q;
		qv = signed'(qs);
		if (qv > 32'sd32767)       mean = 16'h7fff;
		else if (qv < -32'sd32768) mean = 16'h8000;
		else                       mean = qs[MEAN_W-1:0];
	end
	assign position  = pos_q;
	assign block_end = end_q;
endmodule

/* rtl/axis_reduce_mean_unit.sv */
// Top level: streaming mean along one tensor axis in signed Q8.8.
// Usage: samples enter on sample/sample_valid/sample_ready in row-major
// order (outer, reduced axis, inner). A running 32-bit sum per inner
// position lives in a synchronous RAM. On the last row of the reduced axis
// the sum goes to a shared serial divider and the position's mean leaves on
// mean/position/block_end with mean_valid/mean_ready from an output register.
// Each sample passes through accept, RAM read and write back before the next
// one is taken. An emitting sample also starts the serial divider, whose busy
// flag holds sample_ready low until the quotient is handed to the output
// register.
// Reset and any configuration write start a clearing pass over all MAX_INNER
// entries of the sum RAM; no sample is taken during it.
// A stalled receiver holds the mean in the output register. Samples keep
// coming in until the next emitting sample starts the divider; that mean then
// holds sample_ready low until the output register is transferred.
module axis_reduce_mean_unit
	import arm_pkg::*;
#(
	parameter int MAX_INNER   = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  logic [CNT_W-1:0]       cfg_data,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	output logic [MEAN_W-1:0]      mean,
	output logic [9:0]             position,
	output logic                   block_end,
	output logic                   mean_valid,
	input  logic                   mean_ready
);
	localparam int AW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [SUM_W-1:0] sum_mem [MAX_INNER];
	logic [SUM_W-1:0] rd_data_s2;
	logic [1:0]       state_q;
	logic [AW:0]      clr_q;
	logic [ISZ_W-1:0] inner_size_q;
	logic [CNT_W-1:0] count_q;
	logic [AW-1:0]    k_q;
	logic [CNT_W-1:0] row_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic [AW+1:0]    n_eff;
	logic [CNT_W-1:0] c_eff;
	logic             last_row;
	logic             last_pos;
	logic [SUM_W-1:0] new_sum;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [SUM_W-1:0] mem_wd;
	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic             div_ack;
	logic [MEAN_W-1:0] div_mean;
	logic [9:0]       div_position;
	logic             div_block_end;
	logic [MEAN_W-1:0] mean_q;
	logic [9:0]       position_q;
	logic             block_end_q;
	logic             mean_valid_q;
	arm_div_req_t     div_req;
	logic             cfg_hit;

	assign cfg_hit = cfg_we;

	// Effective sizes
	always_comb begin
		if (inner_size_q == '0) n_eff = (AW+2)'(1);
		else if (32'(inner_size_q) > 32'(MAX_INNER)) n_eff = (AW+2)'(MAX_INNER);
		else n_eff = (AW+2)'(inner_size_q);
		c_eff = (count_q == '0) ? CNT_W'(1) : count_q;
	end
	assign last_row = (row_q == c_eff - 1'b1);
	assign last_pos = ({2'b00, k_q} == n_eff - 1'b1);
	assign new_sum  = rd_data_s2 + SUM_W'(signed'(smp_q));

	assign sample_ready = (state_q == ST_IDLE) && !div_busy;

	// Sum RAM, one port write, one registered read
	always_comb begin
		mem_we = 1'b0;
		mem_wa = k_q;
		mem_wd = '0;
		if (state_q == ST_CLR) begin
			mem_we = 1'b1;
			mem_wa = clr_q[AW-1:0];
		end else if (state_q == ST_RD) begin
			mem_we = 1'b1;
			mem_wd = last_row ? '0 : new_sum;
		end
	end
	always_ff @(posedge clk) begin
		if (mem_we) sum_mem[mem_wa] <= mem_wd;
		rd_data_s2 <= sum_mem[k_q];
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			inner_size_q <= ISZ_W'(1);
			count_q      <= CNT_W'(1);
			k_q          <= '0;
			row_q        <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == REG_INNER_SIZE) inner_size_q <= cfg_data[ISZ_W-1:0];
			else                             count_q      <= cfg_data;
			state_q <= ST_CLR;
			clr_q   <= '0;
			k_q     <= '0;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(MAX_INNER - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (sample_valid && sample_ready) begin
						smp_q   <= sample;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: state_q <= ST_RD;
				ST_RD: begin
					state_q <= ST_IDLE;
					if (last_pos) begin
						k_q   <= '0;
						row_q <= last_row ? '0 : row_q + 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	// ST_DIV doubles as the RAM read-wait cycle
	assign div_start          = (state_q == ST_RD) && last_row && !cfg_hit;
	assign div_req.dividend   = new_sum;
	assign div_req.divisor    = c_eff;
	assign div_req.position   = 10'(k_q);
	assign div_req.block_end  = last_pos;

	arm_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.req       (div_req),
		.busy      (div_busy),
		.done      (div_done),
		.mean      (div_mean),
		.position  (div_position),
		.block_end (div_block_end),
		.ack       (div_ack)
	);

	// Output register, loaded from the divider when empty or being transferred
	assign div_ack = div_done && (!mean_valid_q || mean_ready);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_valid_q <= 1'b0;
			mean_q       <= '0;
			position_q   <= '0;
			block_end_q  <= 1'b0;
		end else if (div_ack) begin
			mean_valid_q <= 1'b1;
			mean_q       <= div_mean;
			position_q   <= div_position;
			block_end_q  <= div_block_end;
		end else if (mean_ready) begin
			mean_valid_q <= 1'b0;
		end
	end
	assign mean       = mean_q;
	assign position   = position_q;
	assign block_end  = block_end_q;
	assign mean_valid = mean_valid_q;

	// Checks
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !sample_ready) else $error("sample taken during clear");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(mean_valid && !mean_ready) |=> mean_valid) else $error("result dropped");
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> !sample_ready) else $error("sample taken while divider holds a mean");
endmodule

/* tb/tb_axis_reduce_mean_unit.sv */
// Testbench for axis_reduce_mean_unit: directed and randomized streams checked against a running-mean predictor.
module tb_axis_reduce_mean_unit;
	import arm_pkg::*;

	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [9:0]        position;
		logic              block_end;
	} mean_rec_t;

	localparam int CLEAR_WAIT = 1200;
	localparam int DRAIN_WAIT = 60;
	localparam int STALL_LIMIT = 20000;

	logic clk, arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [CNT_W-1:0] cfg_data;
	logic [15:0] sample;
	logic sample_valid, sample_ready;
	logic [MEAN_W-1:0] mean;
	logic [9:0] position;
	logic block_end, mean_valid, mean_ready;

	axis_reduce_mean_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .sample(sample), .sample_valid(sample_valid),
		.sample_ready(sample_ready), .mean(mean), .position(position),
		.block_end(block_end), .mean_valid(mean_valid), .mean_ready(mean_ready)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// predictor state
	logic [31:0] sums [0:1023];
	int unsigned pos_idx, row_idx, cfg_inner, cfg_count;
	mean_rec_t expected_means[$];
	logic [15:0] pending_samples[$];
	int errors;
	bit quiet;          // no idling in the last part
	bit hold_long;      // long receiver hold-off requested
	bit hold_done;
	int unsigned sent_cnt;

	function automatic void clear_sums();
		for (int i = 0; i < 1024; i++) sums[i] = '0;
		pos_idx = 0;
		row_idx = 0;
	endfunction

	function automatic void apply_cfg(logic idx, logic [15:0] val);
		if (idx == REG_INNER_SIZE) cfg_inner = val & 16'h7FF;
		else cfg_count = val;
		clear_sums();
	endfunction

	// one accepted sample: accumulate, maybe emit
	function automatic void predict_mean(logic [15:0] s);
		int unsigned n, c, k;
		longint q;
		mean_rec_t r;
		n = (cfg_inner == 0) ? 1 : (cfg_inner > 1024 ? 1024 : cfg_inner);
		c = (cfg_count == 0) ? 1 : cfg_count;
		k = (pos_idx >= n) ? 0 : pos_idx;
		if (row_idx >= c) row_idx = 0;
		sums[k] = sums[k] + {{16{s[15]}}, s};
		if (row_idx == c - 1) begin
			q = longint'($signed(sums[k])) / longint'(c);
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			r.mean = q[15:0];
			r.position = k[9:0];
			r.block_end = (k == n - 1);
			expected_means.push_back(r);
			sums[k] = '0;
		end
		k++;
		if (k >= n) begin
			k = 0;
			row_idx++;
			if (row_idx >= c) row_idx = 0;
		end
		pos_idx = k;
	endfunction

	// driver
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			send_gap <= 0;
		end else begin
			if (sample_valid && sample_ready) begin
				predict_mean(sample);
				sent_cnt <= sent_cnt + 1;
			end
			if (!sample_valid || sample_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					if (!quiet && $urandom_range(0, 9) == 0) begin
						send_gap <= $urandom_range(1, 13) - 1;
						sample_valid <= 1'b0;
					end else begin
						sample <= pending_samples.pop_front();
						sample_valid <= 1'b1;
					end
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver
	int recv_gap, idle_cycles;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_ready <= 1'b0;
			recv_gap <= 0;
			idle_cycles <= 0;
			hold_done <= 1'b0;
		end else begin
			if (mean_valid && mean_ready) begin
				if (expected_means.size() == 0) begin
					$display("%0t: unexpected mean %h pos %0d end %0b", $time,
						mean, position, block_end);
					errors++;
				end else begin
					mean_rec_t e;
					e = expected_means.pop_front();
					if (e.mean !== mean)
						$display("%0t: mean expected %h actual %h", $time, e.mean, mean);
					if (e.position !== position)
						$display("%0t: position expected %0d actual %0d", $time,
							e.position, position);
					if (e.block_end !== block_end)
						$display("%0t: block_end expected %0b actual %0b", $time,
							e.block_end, block_end);
					if (e.mean !== mean || e.position !== position
						|| e.block_end !== block_end) errors++;
				end
			end
			if ((mean_valid && mean_ready) || (sample_valid && sample_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				mean_ready <= 1'b0;
			end else if (hold_long && !hold_done) begin
				hold_done <= 1'b1;
				recv_gap <= 400;
				mean_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(1, 13) - 1;
				mean_ready <= 1'b0;
			end else begin
				mean_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("axis_reduce_mean_unit: mismatch");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_samples.size() > 0 || sample_valid || expected_means.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_cfg(idx, val);
		repeat (CLEAR_WAIT) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	// run a random phase; a partial block is dropped by the next register write
	task automatic random_phase(int n_items);
		for (int i = 0; i < n_items; i++) pending_samples.push_back(rand_sample());
		wait_drained();
	endtask

	initial begin
		errors = 0;
		quiet = 0;
		hold_long = 0;
		sent_cnt = 0;
		cfg_we = 1'b0;
		cfg_index = REG_INNER_SIZE;
		cfg_data = '0;
		cfg_inner = 1;
		cfg_count = 1;
		clear_sums();
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (CLEAR_WAIT) @(posedge clk);

		// directed: reset config, extremes pass straight through
		pending_samples.push_back(16'h7FFF);
		pending_samples.push_back(16'h8000);
		pending_samples.push_back(16'h0000);
		pending_samples.push_back(16'hFFFF);
		pending_samples.push_back(16'h0001);
		wait_drained();
		// zero inner size and zero count act as one
		write_reg(REG_INNER_SIZE, 16'd0);
		write_reg(REG_REDUCE_COUNT, 16'd0);
		pending_samples.push_back(16'h8000);
		pending_samples.push_back(16'h1234);
		wait_drained();
		// negative mean truncates toward zero: (-3 + 0)/2
		write_reg(REG_INNER_SIZE, 16'd3);
		write_reg(REG_REDUCE_COUNT, 16'd2);
		pending_samples.push_back(16'hFFFD);
		pending_samples.push_back(16'h8000);
		pending_samples.push_back(16'h7FFF);
		pending_samples.push_back(16'h0000);
		pending_samples.push_back(16'h8000);
		pending_samples.push_back(16'h7FFF);
		wait_drained();
		// inner size above the limit saturates; write mid-stream restarts
		write_reg(REG_INNER_SIZE, 16'h07FF);
		write_reg(REG_REDUCE_COUNT, 16'd1);
		for (int i = 0; i < 5; i++) pending_samples.push_back(rand_sample());
		wait_drained();
		write_reg(REG_INNER_SIZE, 16'd2);
		write_reg(REG_REDUCE_COUNT, 16'd3);
		pending_samples.push_back(16'h7FFF);
		wait_drained();
		repeat (40) @(posedge clk);
		write_reg(REG_REDUCE_COUNT, 16'd3);

		// random phases over several settings
		write_reg(REG_INNER_SIZE, 16'd4);
		write_reg(REG_REDUCE_COUNT, 16'd1);
		hold_long = 1;
		random_phase(120);
		write_reg(REG_INNER_SIZE, 16'd8);
		write_reg(REG_REDUCE_COUNT, 16'd4);
		random_phase(160);
		write_reg(REG_INNER_SIZE, 16'd1);
		write_reg(REG_REDUCE_COUNT, 16'd7);
		random_phase(100);
		write_reg(REG_INNER_SIZE, 16'd1);
		write_reg(REG_REDUCE_COUNT, 16'hFFFF);
		random_phase(20);
		write_reg(REG_INNER_SIZE, 16'd1024);
		write_reg(REG_REDUCE_COUNT, 16'd1);
		random_phase(60);
		write_reg(REG_INNER_SIZE, 16'd3);
		write_reg(REG_REDUCE_COUNT, 16'd2);
		random_phase(120);
		quiet = 1;
		write_reg(REG_INNER_SIZE, 16'd5);
		write_reg(REG_REDUCE_COUNT, 16'd2);
		random_phase(100);

		if (errors == 0)
			$display("axis_reduce_mean_unit: match");
		else
			$display("axis_reduce_mean_unit: mismatch");
		$finish;
	end
endmodule

/* sim.f */
rtl/arm_pkg.sv
rtl/arm_divider.sv
rtl/axis_reduce_mean_unit.sv
tb/tb_axis_reduce_mean_unit.sv
